### sv/rank_roulette_selector_defines.svh
// Assertion macros shared by the rank roulette selector RTL.
// Included by rrs_datapath, the module that carries concurrent assertions.
`ifndef RANK_ROULETTE_SELECTOR_DEFINES_SVH
`define RANK_ROULETTE_SELECTOR_DEFINES_SVH

// Implication checked in the same cycle.
`define RRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rrs_pkg.sv
// Shared types and codes for the rank roulette selector.
// Used by the controller, the datapath and the top level.
package rrs_pkg;

  localparam int unsigned FIT_W = 16;
  localparam int unsigned ID_W  = 8;
  localparam int unsigned REQ_W = 2;
  localparam int unsigned U_W   = 16;
  localparam int unsigned PC_W  = 9;
  localparam int unsigned RANK_W = 9;
  localparam logic [PC_W-1:0] POP_RESET = 9'd256;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_DRAW  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SEL      = 2'd1,
    ST_NOT_FULL = 2'd2,
    ST_FULL     = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DRW_SCAN,
    S_DRW_RD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic  latch;
    logic  clear_fill;
    logic  resp_load;
    stat_e resp_code;
    logic  rd_ins;
    logic  rd_drw;
    logic  wr_shift;
    logic  wr_new;
    logic  scan_step;
    logic  resp_sel;
    logic  push;
  } cmd_t;

  typedef struct packed {
    req_e in_req;
    logic fill_ge_n;
    logic idx_zero;
    logic shift_cond;
    logic scan_hit;
    logic out_free;
  } stat_t;

endpackage

### sv/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rrs_ctrl.sv
// Controller state machine for the rank roulette selector.
// Depends on rrs_pkg; drives rrs_datapath through cmd_t.
module rrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rrs_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output rrs_pkg::cmd_t  cmd_o
);

  rrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.in_req)
            rrs_pkg::REQ_LOAD:
              state_d = stat_i.fill_ge_n ? rrs_pkg::S_RESP : rrs_pkg::S_INS_RD;
            rrs_pkg::REQ_DRAW:
              state_d = stat_i.fill_ge_n ? rrs_pkg::S_DRW_SCAN : rrs_pkg::S_RESP;
            default: state_d = rrs_pkg::S_RESP;
          endcase
        end
      end
      rrs_pkg::S_INS_RD:
        state_d = stat_i.idx_zero ? rrs_pkg::S_RESP : rrs_pkg::S_INS_CMP;
      rrs_pkg::S_INS_CMP:
        state_d = stat_i.shift_cond ? rrs_pkg::S_INS_RD : rrs_pkg::S_RESP;
      rrs_pkg::S_DRW_SCAN:
        if (stat_i.scan_hit) state_d = rrs_pkg::S_DRW_RD;
      rrs_pkg::S_DRW_RD:
        state_d = rrs_pkg::S_RESP;
      rrs_pkg::S_RESP:
        if (stat_i.out_free) state_d = rrs_pkg::S_IDLE;
      default: state_d = rrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.resp_code = rrs_pkg::ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      rrs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (stat_i.in_req)
            rrs_pkg::REQ_CLEAR: begin
              cmd_o.clear_fill = 1'b1;
              cmd_o.resp_load  = 1'b1;
            end
            rrs_pkg::REQ_LOAD: begin
              if (stat_i.fill_ge_n) begin
                cmd_o.resp_load = 1'b1;
                cmd_o.resp_code = rrs_pkg::ST_FULL;
              end
            end
            rrs_pkg::REQ_DRAW: begin
              if (!stat_i.fill_ge_n) begin
                cmd_o.resp_load = 1'b1;
                cmd_o.resp_code = rrs_pkg::ST_NOT_FULL;
              end
            end
            default: cmd_o.resp_load = 1'b1;
          endcase
        end
      end
      rrs_pkg::S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_new    = 1'b1;
          cmd_o.resp_load = 1'b1;
        end else begin
          cmd_o.rd_ins = 1'b1;
        end
      end
      rrs_pkg::S_INS_CMP: begin
        if (stat_i.shift_cond) begin
          cmd_o.wr_shift = 1'b1;
        end else begin
          cmd_o.wr_new    = 1'b1;
          cmd_o.resp_load = 1'b1;
        end
      end
      rrs_pkg::S_DRW_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.rd_drw = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      rrs_pkg::S_DRW_RD: cmd_o.resp_sel = 1'b1;
      rrs_pkg::S_RESP: cmd_o.push = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### sv/rrs_datapath.sv
// Datapath of the rank roulette selector: table RAM, fill count, insertion
// and draw counters, configuration register and output register.
// Depends on rrs_pkg, rrs_ram and the assertion macro header.
`include "rank_roulette_selector_defines.svh"

module rrs_datapath #(
  parameter int unsigned MAX_POP = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrs_pkg::cmd_t               cmd_i,
  output rrs_pkg::stat_t              stat_o,
  input  logic                        cfg_we_i,
  input  logic [rrs_pkg::PC_W-1:0]    cfg_wdata_i,
  output logic [rrs_pkg::PC_W-1:0]    pop_count_o,
  input  logic [rrs_pkg::REQ_W-1:0]   req_type_i,
  input  logic [rrs_pkg::ID_W-1:0]    ind_id_i,
  input  logic [rrs_pkg::FIT_W-1:0]   ind_fitness_i,
  input  logic [rrs_pkg::U_W-1:0]     rand_value_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [rrs_pkg::ID_W-1:0]    sel_id_o,
  output logic [rrs_pkg::RANK_W-1:0]  sel_rank_o
);

  localparam int unsigned AW   = $clog2(MAX_POP);
  localparam int unsigned CW   = $clog2(MAX_POP + 1);
  localparam int unsigned EW   = (CW > rrs_pkg::PC_W) ? CW : rrs_pkg::PC_W;
  localparam int unsigned SW   = 2 * CW;
  localparam int unsigned CMPW = (SW > rrs_pkg::U_W) ? SW : rrs_pkg::U_W;
  localparam int unsigned DW   = rrs_pkg::ID_W + rrs_pkg::FIT_W;

  logic [rrs_pkg::PC_W-1:0]  pop_count_q;
  logic [CW-1:0]             fill_q;
  logic [AW-1:0]             idx_q;
  logic [CW-1:0]             j_q;
  logic [SW-1:0]             cum_q;
  logic [rrs_pkg::ID_W-1:0]  id_q;
  logic [rrs_pkg::FIT_W-1:0] fit_q;
  logic [rrs_pkg::U_W-1:0]   u_q;
  rrs_pkg::stat_e            resp_status_q;
  logic [rrs_pkg::ID_W-1:0]  resp_id_q;
  logic [CW-1:0]             resp_rank_q;
  logic                      out_valid_q;
  logic [1:0]                status_q;
  logic [rrs_pkg::ID_W-1:0]  sel_id_q;
  logic [rrs_pkg::RANK_W-1:0] sel_rank_q;

  logic [EW-1:0] pc_ext, n_ext;
  logic [CW-1:0] n_eff;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // Effective population size, clamped to the legal range.
  always_comb begin
    pc_ext = EW'(pop_count_q);
    if (pc_ext < EW'(2)) begin
      n_ext = EW'(2);
    end else if (pc_ext > EW'(MAX_POP)) begin
      n_ext = EW'(MAX_POP);
    end else begin
      n_ext = pc_ext;
    end
    n_eff = CW'(n_ext);
  end

  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_new;
  assign ram_waddr = idx_q;
  assign ram_wdata = cmd_i.wr_new ? {id_q, fit_q} : ram_rdata;
  assign ram_re    = cmd_i.rd_ins | cmd_i.rd_drw;
  assign ram_raddr = cmd_i.rd_drw ? AW'(j_q - CW'(1)) : (idx_q - AW'(1));

  rrs_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_POP)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    stat_o.in_req     = rrs_pkg::req_e'(req_type_i);
    stat_o.fill_ge_n  = (fill_q >= n_eff);
    stat_o.idx_zero   = (idx_q == '0);
    // Entries with equal fitness stay below the new one.
    stat_o.shift_cond = (ram_rdata[rrs_pkg::FIT_W-1:0] > fit_q);
    stat_o.scan_hit   = (CMPW'(u_q) < CMPW'(cum_q)) || (j_q == CW'(1));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_count_q <= rrs_pkg::POP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pop_count_q <= cfg_wdata_i;
      if (cmd_i.clear_fill) begin
        fill_q <= '0;
      end else if (cmd_i.wr_new) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q  <= ind_id_i;
      fit_q <= ind_fitness_i;
      u_q   <= rand_value_i;
      idx_q <= AW'(fill_q);
      j_q   <= n_eff;
      cum_q <= SW'(n_eff);
    end
    if (cmd_i.wr_shift) idx_q <= idx_q - AW'(1);
    // Walk down from the fittest rank, growing the cumulative weight.
    if (cmd_i.scan_step) begin
      j_q   <= j_q - CW'(1);
      cum_q <= cum_q + SW'(j_q - CW'(1));
    end
    if (cmd_i.resp_load) begin
      resp_status_q <= cmd_i.resp_code;
      resp_id_q     <= '0;
      resp_rank_q   <= '0;
    end else if (cmd_i.resp_sel) begin
      resp_status_q <= rrs_pkg::ST_SEL;
      resp_id_q     <= ram_rdata[DW-1:rrs_pkg::FIT_W];
      resp_rank_q   <= j_q;
    end
    if (cmd_i.push) begin
      status_q   <= resp_status_q;
      sel_id_q   <= resp_id_q;
      sel_rank_q <= rrs_pkg::RANK_W'(resp_rank_q);
    end
  end

  assign pop_count_o = pop_count_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign sel_id_o    = sel_id_q;
  assign sel_rank_o  = sel_rank_q;

  `RRS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(MAX_POP), "fill count above table depth")
  `RRS_ASSERT_NOW(a_one_write, ram_we, !(cmd_i.wr_shift && cmd_i.wr_new), "two table writes")
  `RRS_ASSERT_NOW(a_push_free, cmd_i.push, !out_valid_q || out_ready_i, "result overwritten")
  `RRS_ASSERT_NOW(a_scan_floor, cmd_i.scan_step, j_q > CW'(1), "rank scan below rank one")
  `RRS_ASSERT_NEXT(a_ins_grow, cmd_i.wr_new && !cmd_i.clear_fill, fill_q != '0,
                   "insert did not grow table")

endmodule

### sv/rank_roulette_selector.sv
// Top level of the rank roulette selector: APB register decode and the
// controller and datapath. Depends on rrs_pkg, rrs_ctrl and rrs_datapath.
//
// Usage: each input item (req_type_i, ind_id_i, ind_fitness_i, rand_value_i)
// is taken on in_valid_i & in_ready_o and yields exactly one result item
// (status_o, sel_id_o, sel_rank_o) on out_valid_o & out_ready_i.
// A clear item, an unused-code item, and a load item into a full table, go straight to the response;
// otherwise a load walks the table from its top end down to the insertion
// point, reading each entry on the way and shifting up each one that is
// fitter than the new item. A draw item on a table that is not full also
// goes straight to the response; otherwise it scans ranks from the fittest
// downward at one rank per cycle, then reads the table RAM. One item is
// worked on at a time.
// Results sit in an output register; a stalled receiver holds that register
// while the next item is worked, and that item's result waits until the
// register frees up.
// Reset empties the table and sets pop_count to 256. The table RAM is not
// cleared; only entries written since the last clear are ever read.
// pop_count (register 0, byte address 0) must be written only while idle; the block does not enforce this.
module rank_roulette_selector #(
  parameter int unsigned MAX_POP = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rrs_pkg::REQ_W-1:0]   req_type_i,
  input  logic [rrs_pkg::ID_W-1:0]    ind_id_i,
  input  logic [rrs_pkg::FIT_W-1:0]   ind_fitness_i,
  input  logic [rrs_pkg::U_W-1:0]     rand_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [rrs_pkg::ID_W-1:0]    sel_id_o,
  output logic [rrs_pkg::RANK_W-1:0]  sel_rank_o
);

  rrs_pkg::cmd_t            cmd;
  rrs_pkg::stat_t           stat;
  logic                     cfg_we;
  logic [rrs_pkg::PC_W-1:0] pop_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? 32'(pop_count) : 32'd0;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rrs_datapath #(
    .MAX_POP(MAX_POP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[rrs_pkg::PC_W-1:0]),
    .pop_count_o   (pop_count),
    .req_type_i    (req_type_i),
    .ind_id_i      (ind_id_i),
    .ind_fitness_i (ind_fitness_i),
    .rand_value_i  (rand_value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .sel_id_o      (sel_id_o),
    .sel_rank_o    (sel_rank_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the rank roulette selector.
// Drives clear, load, draw and unused-code items plus APB writes of pop_count; depends on rrs_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] sel_id;
    logic [8:0] sel_rank;
  } selection_t;

  // Ranking predictor with its own table and queue of pending selections.
  class rank_board;
    logic [15:0] fit_tab[256];
    logic [7:0]  id_tab[256];
    int unsigned fill;
    int unsigned pop;
    selection_t  pending[$];
    int          errors;

    function new();
      fill = 0;
      pop = 256;
      errors = 0;
    endfunction

    function void note_item(logic [1:0] req, logic [7:0] id, logic [15:0] fit,
                            logic [15:0] u);
      int unsigned n, pos, s, cum, j, uu;
      selection_t r;
      n = pop < 2 ? 2 : (pop > 256 ? 256 : pop);
      r = '0;
      if (req == rrs_pkg::REQ_CLEAR) begin
        fill = 0;
      end else if (req == rrs_pkg::REQ_LOAD) begin
        if (fill >= n) begin
          r.status = rrs_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && fit_tab[pos] <= fit) pos++;
          for (int i = fill; i > pos; i--) begin
            fit_tab[i] = fit_tab[i-1];
            id_tab[i] = id_tab[i-1];
          end
          fit_tab[pos] = fit;
          id_tab[pos] = id;
          fill++;
        end
      end else if (req == rrs_pkg::REQ_DRAW) begin
        if (fill < n) begin
          r.status = rrs_pkg::ST_NOT_FULL;
        end else begin
          s = n * (n + 1) / 2;
          uu = (u >= s) ? s - 1 : u;
          cum = 0;
          r.sel_rank = 9'd1;
          for (j = n; j >= 1; j--) begin
            cum += j;
            if (uu < cum) begin
              r.sel_rank = 9'(j);
              break;
            end
          end
          r.sel_id = id_tab[r.sel_rank - 1];
          r.status = rrs_pkg::ST_SEL;
        end
      end
      pending = {pending, r};
    endfunction

    function void check_result(selection_t act);
      selection_t e;
      if (pending.size() == 0) begin
        $error("result item with no item pending: status %0d", act.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, act.status);
        errors++;
      end
      if (act.sel_id !== e.sel_id) begin
        $error("sel_id: expected %0d, actual %0d", e.sel_id, act.sel_id);
        errors++;
      end
      if (act.sel_rank !== e.sel_rank) begin
        $error("sel_rank: expected %0d, actual %0d", e.sel_rank, act.sel_rank);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [7:0]  ind_id_i = '0;
  logic [15:0] ind_fitness_i = '0;
  logic [15:0] rand_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  sel_id_o;
  logic [8:0]  sel_rank_o;

  rank_roulette_selector uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rank_board board = new();
  int send_idle_pct = 36;
  int recv_idle_pct = 72;
  int quiet_cycles = 0;

  // Receiver: random stall, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result({status_o, sel_id_o, sel_rank_o});
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > 4000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // Valid stays high after an accepted item until the next call either
  // idles or replaces the payload, so each edge sees one assignment only.
  task automatic send_item(logic [1:0] req, logic [7:0] id, logic [15:0] fit,
                           logic [15:0] u);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    ind_id_i <= id;
    ind_fitness_i <= fit;
    rand_value_i <= u;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(req, id, fit, u);
    @(negedge clk_i);
  endtask

  // Waits for all results, then a margin for the block to settle, then writes.
  task automatic write_pop(int unsigned value);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.pop = value & 9'h1FF;
  endtask

  // Clears the table, then fills it with n random loads, mostly from a narrow
  // fitness range so that ties are frequent.
  task automatic fill_table(int unsigned n);
    send_item(rrs_pkg::REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++)
      send_item(rrs_pkg::REQ_LOAD, 8'($urandom),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7)),
                16'($urandom));
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned sent, n, r;
    sent = 0;
    while (sent < items) begin
      n = (board.pop < 2) ? 2 : board.pop;
      fill_table(n);
      sent += n + 1;
      for (int k = 0; k < 12; k++) begin
        r = $urandom_range(9);
        if (r < 7)
          send_item(rrs_pkg::REQ_DRAW, 8'($urandom), 16'($urandom),
                    ($urandom_range(1) == 1) ? 16'($urandom_range(n * (n + 1) / 2))
                                             : 16'($urandom));
        else if (r == 7)
          send_item(rrs_pkg::REQ_LOAD, 8'($urandom), 16'($urandom), 16'($urandom));
        else
          send_item(rrs_pkg::REQ_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
      if ($urandom_range(4) == 0) begin
        send_item(rrs_pkg::REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
        send_item(rrs_pkg::REQ_DRAW, 8'($urandom), 16'($urandom), 16'($urandom));
        sent += 2;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: draw on empty table, unused code, minimum population with ties.
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'hFFFF);
    send_item(rrs_pkg::REQ_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
    write_pop(0);
    send_item(rrs_pkg::REQ_LOAD, 8'hFF, 16'hFFFF, 16'd0);
    send_item(rrs_pkg::REQ_LOAD, 8'h00, 16'hFFFF, 16'd0);
    send_item(rrs_pkg::REQ_LOAD, 8'h55, 16'd0, 16'd0);
    for (int u = 0; u < 4; u++) send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'(u));
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'hFFFF);
    write_pop(9'h1FF);
    fill_table(256);
    send_item(rrs_pkg::REQ_LOAD, 8'hAA, 16'h1234, 16'd0);
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'd0);
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'd32895);
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'hFFFF);
    // Lowering the population leaves a table fuller than N.
    write_pop(5);
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'd0);
    send_item(rrs_pkg::REQ_DRAW, 8'd0, 16'd0, 16'd14);
    send_item(rrs_pkg::REQ_LOAD, 8'd1, 16'd1, 16'd0);
    write_pop(8);
    random_phase(400);
    send_idle_pct = 72;
    recv_idle_pct = 36;
    write_pop(3);
    random_phase(350);
    write_pop(20);
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_pop(2);
    random_phase(200);
    write_pop(256);
    random_phase(60);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (board.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
